// ----- rtl/hsk_pkg.sv -----
// Shared types and constants for the heap sort key block.
`default_nettype none
package hsk_pkg;

  localparam int KEY_W        = 64;
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BYTES_DEF = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_RD,
    ST_BUILD_LD,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  typedef enum logic [1:0] {
    PICK_NODE,
    PICK_LEFT,
    PICK_RIGHT
  } pick_t;

endpackage
`default_nettype wire

// ----- rtl/hsk_ram.sv -----
// Key store: one write port, two registered read ports.
`default_nettype none
module hsk_ram #(
  parameter int DEPTH = hsk_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(hsk_pkg::CAPACITY_DEF),
  parameter int DW    = hsk_pkg::KEY_W
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output      logic [DW-1:0] rdata_a,
  output      logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ----- rtl/hsk_pick.sv -----
// Compare unit: picks the largest of a node and its two children.
`default_nettype none
module hsk_pick #(
  parameter int DW = hsk_pkg::KEY_W
) (
  input  wire logic [DW-1:0] cur,
  input  wire logic [DW-1:0] left,
  input  wire logic [DW-1:0] right,
  input  wire logic          left_ok,
  input  wire logic          right_ok,
  output hsk_pkg::pick_t     sel
);

  logic l_gt_c;
  logic r_gt_c;
  logic r_gt_l;
  logic take_l;
  logic take_r;

  // three compares side by side, then a small select
  assign l_gt_c = left > cur;
  assign r_gt_c = right > cur;
  assign r_gt_l = right > left;
  assign take_l = left_ok && l_gt_c;
  assign take_r = right_ok && (take_l ? r_gt_l : r_gt_c);

  always_comb begin
    if (take_r) begin
      sel = hsk_pkg::PICK_RIGHT;
    end else if (take_l) begin
      sel = hsk_pkg::PICK_LEFT;
    end else begin
      sel = hsk_pkg::PICK_NODE;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/heap_sort_keys_top.sv -----
// Heap sort of key sets: load, heapify, extract and stream out in ascending order.
//
//  channel | dir | tdata           | tlast    | tuser
//  s_*     | in  | key[63:0]       | is_last  | -
//  m_*     | out | sorted_key[63:0]| last_out | overflow
//
// Loading takes one word per cycle; s_tready is high only between runs.
// After the closing word the heap is built and drained by one sift loop doing, per
// level, a registered store read, then a compare and write back; each sift start
// or swap adds its own store read step and a load or write back step.
// Each result is read from the store, then registered; a stalled m_tready holds.
// Reset clears control only; the key store keeps no reset value.
`default_nettype none
module heap_sort_keys_top #(
  parameter int CAPACITY  = hsk_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = hsk_pkg::KEY_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [63:0] s_tdata,   // [63:0] key
  input  wire logic        s_tlast,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [63:0] m_tdata,   // [63:0] sorted_key
  output      logic        m_tlast,
  output      logic        m_tuser    // [0] overflow
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = AW + 2;
  localparam int KW    = hsk_pkg::KEY_W;
  localparam logic [KW-1:0] KEY_MASK = {KW{1'b1}} << (KW - 8 * KEY_BYTES);

  hsk_pkg::state_t state, state_next;

  logic [CNT_W-1:0] count, count_next;
  logic             drop, drop_next;
  logic             run_ovf, run_ovf_next;
  logic [AW-1:0]    last_idx, last_idx_next;
  logic [AW-1:0]    par, par_next;
  logic [AW-1:0]    tail, tail_next;
  logic [AW-1:0]    node, node_next;
  logic [AW-1:0]    oidx, oidx_next;
  logic [CNT_W-1:0] size, size_next;
  logic             build_ph, build_ph_next;
  logic [KW-1:0]    cur, cur_next;
  logic             out_valid, out_valid_next;
  logic [KW-1:0]    out_key, out_key_next;
  logic             out_last, out_last_next;
  logic             out_ovf, out_ovf_next;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_ra;
  logic [AW-1:0]    ram_rb;
  logic [KW-1:0]    rd_a;
  logic [KW-1:0]    rd_b;

  logic [CW-1:0]    lc;
  logic [CW-1:0]    rc;
  logic             left_ok;
  logic             right_ok;
  hsk_pkg::pick_t   sel;
  logic             room;
  logic [CNT_W-1:0] ncount;
  logic             in_acc;

  assign lc       = CW'({node, 1'b1});
  assign rc       = lc + CW'(1);
  assign left_ok  = lc < CW'(size);
  assign right_ok = rc < CW'(size);
  assign room     = count < CNT_W'(CAPACITY);
  assign ncount   = room ? count + CNT_W'(1) : count;
  assign in_acc   = s_tvalid && s_tready;

  assign s_tready = (state == hsk_pkg::ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_key;
  assign m_tlast  = out_last;
  assign m_tuser  = out_ovf;

  hsk_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (KW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_ra),
    .raddr_b (ram_rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  hsk_pick #(
    .DW (KW)
  ) u_pick (
    .cur      (cur),
    .left     (rd_a),
    .right    (rd_b),
    .left_ok  (left_ok),
    .right_ok (right_ok),
    .sel      (sel)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    drop_next      = drop;
    run_ovf_next   = run_ovf;
    last_idx_next  = last_idx;
    par_next       = par;
    tail_next      = tail;
    node_next      = node;
    oidx_next      = oidx;
    size_next      = size;
    build_ph_next  = build_ph;
    cur_next       = cur;
    out_valid_next = out_valid && !m_tready;
    out_key_next   = out_key;
    out_last_next  = out_last;
    out_ovf_next   = out_ovf;
    ram_we         = 1'b0;
    ram_waddr      = count[AW-1:0];
    ram_wdata      = s_tdata & KEY_MASK;
    ram_ra         = node;
    ram_rb         = node;

    unique case (state)
      hsk_pkg::ST_IDLE: begin
        if (in_acc) begin
          ram_we = room;
          if (s_tlast) begin
            last_idx_next = AW'(ncount - CNT_W'(1));
            run_ovf_next  = drop || !room;
            count_next    = '0;
            drop_next     = 1'b0;
            oidx_next     = '0;
            par_next      = last_idx_next >> 1;
            if (last_idx_next == '0) begin
              state_next = hsk_pkg::ST_OUT_RD;
            end else begin
              state_next = hsk_pkg::ST_BUILD_RD;
            end
          end else begin
            count_next = ncount;
            drop_next  = drop || !room;
          end
        end
      end
      hsk_pkg::ST_BUILD_RD: begin
        ram_ra     = par;
        state_next = hsk_pkg::ST_BUILD_LD;
      end
      hsk_pkg::ST_BUILD_LD: begin
        cur_next      = rd_a;
        node_next     = par;
        size_next     = CNT_W'(last_idx) + CNT_W'(1);
        build_ph_next = 1'b1;
        state_next    = hsk_pkg::ST_SIFT_RD;
      end
      hsk_pkg::ST_SIFT_RD: begin
        ram_ra     = lc[AW-1:0];
        ram_rb     = rc[AW-1:0];
        state_next = hsk_pkg::ST_SIFT_CMP;
      end
      hsk_pkg::ST_SIFT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = node;
        case (sel)
          hsk_pkg::PICK_LEFT: begin
            ram_wdata  = rd_a;
            node_next  = lc[AW-1:0];
            state_next = hsk_pkg::ST_SIFT_RD;
          end
          hsk_pkg::PICK_RIGHT: begin
            ram_wdata  = rd_b;
            node_next  = rc[AW-1:0];
            state_next = hsk_pkg::ST_SIFT_RD;
          end
          default: begin
            // held key settles here; pick the next sift or start the output
            ram_wdata = cur;
            if (build_ph) begin
              if (par != '0) begin
                par_next   = par - AW'(1);
                state_next = hsk_pkg::ST_BUILD_RD;
              end else begin
                build_ph_next = 1'b0;
                tail_next     = last_idx;
                state_next    = hsk_pkg::ST_SWAP_RD;
              end
            end else if (tail == AW'(1)) begin
              oidx_next  = '0;
              state_next = hsk_pkg::ST_OUT_RD;
            end else begin
              tail_next  = tail - AW'(1);
              state_next = hsk_pkg::ST_SWAP_RD;
            end
          end
        endcase
      end
      hsk_pkg::ST_SWAP_RD: begin
        ram_ra     = '0;
        ram_rb     = tail;
        state_next = hsk_pkg::ST_SWAP_WR;
      end
      hsk_pkg::ST_SWAP_WR: begin
        // root goes to the tail; the old tail key sifts down from the root
        ram_we     = 1'b1;
        ram_waddr  = tail;
        ram_wdata  = rd_a;
        cur_next   = rd_b;
        node_next  = '0;
        size_next  = CNT_W'(tail);
        state_next = hsk_pkg::ST_SIFT_RD;
      end
      hsk_pkg::ST_OUT_RD: begin
        ram_ra     = oidx;
        state_next = hsk_pkg::ST_OUT_LD;
      end
      hsk_pkg::ST_OUT_LD: begin
        ram_ra = oidx;
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_key_next   = rd_a;
          out_last_next  = (oidx == last_idx);
          out_ovf_next   = run_ovf;
          if (oidx == last_idx) begin
            state_next = hsk_pkg::ST_IDLE;
          end else begin
            oidx_next  = oidx + AW'(1);
            state_next = hsk_pkg::ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = hsk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hsk_pkg::ST_IDLE;
      count     <= '0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
      build_ph  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      drop      <= drop_next;
      out_valid <= out_valid_next;
      build_ph  <= build_ph_next;
    end
  end

  always_ff @(posedge clk) begin
    run_ovf  <= run_ovf_next;
    last_idx <= last_idx_next;
    par      <= par_next;
    tail     <= tail_next;
    node     <= node_next;
    oidx     <= oidx_next;
    size     <= size_next;
    cur      <= cur_next;
    out_key  <= out_key_next;
    out_last <= out_last_next;
    out_ovf  <= out_ovf_next;
  end

endmodule
`default_nettype wire

// ----- rtl/hsk_chk.sv -----
// Port-level checks for the heap sort key block, bound to the top level.
`default_nettype none
module hsk_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result word changed");

  // closing word starts the sort, so input must close
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input open right after closing word");

  // while a run is still being streamed no new key is taken
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input open in the middle of a run");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind heap_sort_keys_top hsk_chk u_chk (.*);
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for heap_sort_keys_top: key sets in, checked against an ascending-sort predictor.
module tb;

  localparam int CAPACITY     = hsk_pkg::CAPACITY_DEF;
  localparam int KEY_BYTES    = hsk_pkg::KEY_BYTES_DEF;
  localparam logic [63:0] KEY_MASK = {64{1'b1}} << (64 - 8 * KEY_BYTES);
  localparam int RANDOM_ITEMS = 90;
  localparam int DRAIN_TAIL   = 24;
  localparam int LIMIT_CYCLES = 600000;

  typedef enum int {
    GAPS_NONE,
    GAPS_FULL,
    GAPS_SPARSE
  } gap_mode_t;

  typedef struct packed {
    logic [63:0] key;
    logic        is_end;
    logic        ovf;
  } sorted_word_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  // keys of the set being loaded, and the words still owed by the block
  logic [63:0]  held_keys[$];
  logic         keys_lost = 1'b0;
  sorted_word_t pending_sorted[$];

  gap_mode_t tx_mode = GAPS_NONE;
  gap_mode_t rx_mode = GAPS_NONE;
  int        errors  = 0;
  int        cycles  = 0;

  heap_sort_keys_top #(
    .CAPACITY (CAPACITY),
    .KEY_BYTES(KEY_BYTES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int draw_gap(input gap_mode_t mode);
    case (mode)
      GAPS_FULL:   draw_gap = $urandom_range(0, 13);
      GAPS_SPARSE: draw_gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
      default:     draw_gap = 0;
    endcase
  endfunction

  // text packed big-endian, zero padded
  function automatic logic [63:0] text_key(input string s);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) k[63 - 8 * i -: 8] = s[i];
    text_key = k;
  endfunction

  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    int          len;
    k = '0;
    case ($urandom_range(0, 3))
      0: k = {$urandom, $urandom};
      1: begin
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) k[63 - 8 * i -: 8] = 8'($urandom_range(8'h20, 8'h7e));
      end
      // small pool so that sets carry equal keys and shared prefixes
      2: k = text_key($urandom_range(0, 1) ? "key" : "keys") | 64'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0: k = '0;
          1: k = '1;
          2: k = 64'h8000_0000_0000_0000;
          default: k = 64'h7fff_ffff_ffff_ffff;
        endcase
      end
    endcase
    rand_key = k;
  endfunction

  // predictor: store the key if there is room, sort and emit on the closing word
  function automatic void collect_key(input logic [63:0] key, input logic is_end);
    sorted_word_t w;
    if (held_keys.size() < CAPACITY) held_keys.push_back(key & KEY_MASK);
    else keys_lost = 1'b1;
    if (is_end) begin
      held_keys.sort();
      foreach (held_keys[i]) begin
        w.key    = held_keys[i];
        w.is_end = (i == held_keys.size() - 1);
        w.ovf    = keys_lost;
        pending_sorted.push_back(w);
      end
      held_keys.delete();
      keys_lost = 1'b0;
    end
  endfunction

  task automatic send_key(input logic [63:0] key, input logic is_end);
    int gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= key;
    s_tlast  <= is_end;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    collect_key(key, is_end);
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_key(rand_key(), i == n - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // receiver: random hold-off before each word, ready kept high across back-to-back words
  initial begin : rx_side
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(rx_mode);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  always @(posedge clk) begin
    sorted_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sorted.size() == 0) begin
        $error("unexpected word: sorted_key %h last %b overflow %b", m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        want = pending_sorted.pop_front();
        if (m_tdata !== want.key) begin
          $error("sorted_key: expected %h, got %h", want.key, m_tdata);
          errors++;
        end
        if (m_tlast !== want.is_end) begin
          $error("last_out: expected %b, got %b", want.is_end, m_tlast);
          errors++;
        end
        if (m_tuser !== want.ovf) begin
          $error("overflow: expected %b, got %b", want.ovf, m_tuser);
          errors++;
        end
      end
    end
  end

  // one-key sets at both ends of the range and one text key
  task automatic test_single_keys();
    tx_mode = GAPS_NONE;
    rx_mode = GAPS_NONE;
    send_key('1, 1'b1);
    send_key('0, 1'b1);
    send_key(text_key("a"), 1'b1);
  endtask

  task automatic test_extreme_keys();
    tx_mode = GAPS_FULL;
    rx_mode = GAPS_FULL;
    // descending input, equal keys, sign bit and text with shared prefix
    send_key('1, 1'b0);
    send_key(64'h8000_0000_0000_0000, 1'b0);
    send_key(64'h7fff_ffff_ffff_ffff, 1'b0);
    send_key(text_key("apples"), 1'b0);
    send_key(text_key("apple"), 1'b0);
    send_key(64'h1, 1'b0);
    send_key('0, 1'b0);
    send_key('0, 1'b1);
    tx_mode = GAPS_SPARSE;
    rx_mode = GAPS_NONE;
    send_key('0, 1'b0);
    send_key(64'h0101_0101_0101_0101, 1'b0);
    send_key(text_key("zzzzzzzz"), 1'b0);
    send_key(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    send_key(64'h5555_5555_5555_5555, 1'b0);
    send_key('1, 1'b1);
  endtask

  // full store, closing word dropped, several dropped words
  task automatic test_full_store();
    tx_mode = GAPS_SPARSE;
    rx_mode = GAPS_SPARSE;
    send_set(CAPACITY);
    send_set(CAPACITY + 1);
    wait_drained();
    tx_mode = GAPS_NONE;
    rx_mode = GAPS_FULL;
    send_set(CAPACITY + 6);
    send_set(2);
  endtask

  task automatic test_random_sets();
    int sent;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_mode = gap_mode_t'($urandom_range(0, 2));
      rx_mode = gap_mode_t'($urandom_range(0, 2));
      if ($urandom_range(0, 5) == 0) wait_drained();
      case ($urandom_range(0, 19))
        0:       n = $urandom_range(CAPACITY + 1, CAPACITY + 8);
        1, 2, 3: n = $urandom_range(13, CAPACITY);
        default: n = $urandom_range(1, 12);
      endcase
      send_set(n);
      sent += n;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_keys();
    test_extreme_keys();
    wait_drained();
    test_full_store();
    test_random_sets();
    wait_drained();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
